// File: hw/rtl/gregorian_date_midpoint_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the date midpoint block
// Each macro expands to one labeled concurrent assertion on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_MIDPOINT_TOP_ASSERT_SVH
`define GREGORIAN_DATE_MIDPOINT_TOP_ASSERT_SVH

// Same-cycle implication
`define GDM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define GDM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gdm_pkg.sv
// ----------------------------------------------------------------------------
// gdm_pkg
// Widths, calendar constants, reciprocal dividers and per-date helper
// functions for the Gregorian date midpoint pipeline.
// ----------------------------------------------------------------------------
package gdm_pkg;

    // Field widths
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MON_W   = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned TOTAL_W = 22;

    // Calendar constants
    localparam int unsigned YEAR_LIMIT       = 9999;
    localparam int unsigned DAYS_PER_ERA     = 146097;
    localparam int unsigned DAYS_PER_CENTURY = 36524;

    // Pipeline depth, input register to output register
    localparam int unsigned STAGES = 13;

    // Reciprocal constants, rounded up, exact over the value ranges used here
    localparam int unsigned DIV25_SH  = 17;
    localparam int unsigned DIV25_K   = (2**DIV25_SH + 24) / 25;
    localparam int unsigned DIV365_SH = 28;
    localparam int unsigned DIV365_K  = (2**DIV365_SH + 364) / 365;
    localparam int unsigned DIV153_SH = 18;
    localparam int unsigned DIV153_K  = (2**DIV153_SH + 152) / 153;

    // Era estimate: rounded down, one correction step afterwards
    localparam int unsigned ERA_PRE = 8;
    localparam int unsigned ERA_SH  = 24;
    localparam int unsigned ERA_K   = (2**ERA_SH) / DAYS_PER_ERA;

    // First pass on one date: clamped fields, March-based year and month
    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
        logic [YEAR_W-1:0] yy;
        logic [3:0]        mp;
        logic [6:0]        qy;
        logic [6:0]        qyy;
    } date_a_t;

    // Second pass on one date: day number parts
    typedef struct packed {
        logic [TOTAL_W-1:0] base;
        logic [6:0]         qyy;
        logic [8:0]         doy;
    } date_b_t;

    // Result fields carried alongside the midpoint day number
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               noon;
        logic               rev;
    } meta_t;

    // x / 25 for x below 3200
    function automatic logic [6:0] div25(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'(DIV25_K);
        return p[DIV25_SH+6:DIV25_SH];
    endfunction

    // x / 365 for x below 2^18
    function automatic logic [9:0] div365(input logic [17:0] x);
        logic [37:0] p;
        p = 38'(x) * 38'(DIV365_K);
        return p[DIV365_SH+9:DIV365_SH];
    endfunction

    // x / 153 for x below 2048
    function automatic logic [3:0] div153(input logic [10:0] x);
        logic [21:0] p;
        p = 22'(x) * 22'(DIV153_K);
        return p[DIV153_SH+3:DIV153_SH];
    endfunction

    // First day of each month, counted from March 1
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Days in a month, January based
    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        if (y == '0)
            r = YEAR_W'(1);
        else if (y > YEAR_W'(YEAR_LIMIT))
            r = YEAR_W'(YEAR_LIMIT);
        else
            r = y;
        return r;
    endfunction

    function automatic logic [MON_W-1:0] clamp_month(input logic [MON_W-1:0] m);
        logic [MON_W-1:0] r;
        if (m == '0)
            r = MON_W'(1);
        else if (m > MON_W'(12))
            r = MON_W'(12);
        else
            r = m;
        return r;
    endfunction

    // Clamp year and month, shift to a March-based year, take centuries
    function automatic date_a_t date_pass_a(input logic [DAY_W-1:0]  d,
                                            input logic [MON_W-1:0]  m,
                                            input logic [YEAR_W-1:0] y);
        date_a_t          r;
        logic [YEAR_W-1:0] yc;
        logic [MON_W-1:0]  mc;
        yc      = clamp_year(y);
        mc      = clamp_month(m);
        r.day   = d;
        r.month = mc;
        r.year  = yc;
        r.yy    = (mc <= MON_W'(2)) ? yc - YEAR_W'(1) : yc;
        r.mp    = (mc > MON_W'(2)) ? mc - 4'd3 : mc + 4'd9;
        r.qy    = div25(12'(yc >> 2));
        r.qyy   = div25(12'(r.yy >> 2));
        return r;
    endfunction

    // Leap test, clamp day, day of year and the linear year term
    function automatic date_b_t date_pass_b(input date_a_t a);
        date_b_t           b;
        logic [YEAR_W-1:0] r100;
        logic              leap;
        logic [DAY_W-1:0]  len;
        logic [DAY_W-1:0]  dc;
        r100 = a.year - YEAR_W'(14'(a.qy) * 14'd100);
        leap = (r100 == '0) ? (a.qy[1:0] == 2'd0) : (a.year[1:0] == 2'd0);
        len  = month_len(a.month, leap);
        if (a.day == '0)
            dc = DAY_W'(1);
        else if (a.day > len)
            dc = len;
        else
            dc = a.day;
        b.doy  = month_start(a.mp) + 9'(dc) - 9'd1;
        b.base = TOTAL_W'(22'(a.yy) * 22'd365) + TOTAL_W'(a.yy >> 2);
        b.qyy  = a.qyy;
        return b;
    endfunction

    // Finish the day number, counted from March 1 of year 0
    function automatic logic [TOTAL_W-1:0] date_pass_c(input date_b_t b);
        return b.base - TOTAL_W'(b.qyy) + TOTAL_W'(b.qyy >> 2) + TOTAL_W'(b.doy);
    endfunction

endpackage

// File: hw/rtl/gdm_req_if.sv
// ----------------------------------------------------------------------------
// gdm_req_if
// Request channel: one word carries a start date and an end date.
// ----------------------------------------------------------------------------
interface gdm_req_if
    import gdm_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  start_day;
    logic [MON_W-1:0]  start_month;
    logic [YEAR_W-1:0] start_year;
    logic [DAY_W-1:0]  end_day;
    logic [MON_W-1:0]  end_month;
    logic [YEAR_W-1:0] end_year;

    modport source (
        output valid, start_day, start_month, start_year,
        output end_day, end_month, end_year,
        input  ready
    );

    modport sink (
        input  valid, start_day, start_month, start_year,
        input  end_day, end_month, end_year,
        output ready
    );
endinterface

// File: hw/rtl/gdm_rsp_if.sv
// ----------------------------------------------------------------------------
// gdm_rsp_if
// Response channel: day count, midpoint date and flags, one word per request.
// ----------------------------------------------------------------------------
interface gdm_rsp_if
    import gdm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] total_days;
    logic [DAY_W-1:0]   mid_day;
    logic [MON_W-1:0]   mid_month;
    logic [YEAR_W-1:0]  mid_year;
    logic               noon_flag;
    logic               reversed;

    modport source (
        output valid, total_days, mid_day, mid_month, mid_year,
        output noon_flag, reversed,
        input  ready
    );

    modport sink (
        input  valid, total_days, mid_day, mid_month, mid_year,
        input  noon_flag, reversed,
        output ready
    );
endinterface

// File: hw/rtl/gregorian_date_midpoint_top.sv
// ----------------------------------------------------------------------------
// Gregorian date midpoint
// Day count between two dates and the date halfway between them.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a start and an end date (valid/ready); rsp returns one word
//   per request: total_days, the midpoint date, noon_flag (odd day count)
//   and reversed (end before start; total 0, midpoint is the start date).
//   Out-of-range days, months and years are clamped before use.
//   Accepted words pass through a 13-stage pipeline to rsp; one word per
//   cycle sustained while rsp.ready stays high.
//   The depth is set by the chain of reciprocal multiplies that turns the
//   midpoint day number back into a date (era, year of era, month).
//   Reset clears all stage valid bits; the pipeline comes up empty.
//   When rsp stalls, the output word holds and each stage fills its bubble
//   before it stops, so req.ready falls only once every stage is full.
// ----------------------------------------------------------------------------
module gregorian_date_midpoint_top
    import gdm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    gdm_req_if.sink   req,
    gdm_rsp_if.source rsp
);

    // Stage valid bits and per-stage advance
    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] adv;

    // Stage 1..3: day numbers of both dates
    date_a_t            sa_reg, ea_reg, sa_next, ea_next;
    date_b_t            sb_reg, eb_reg, sb_next, eb_next;
    logic [TOTAL_W-1:0] zs3_reg, ze3_reg, zs3_next, ze3_next;

    // Stage 4..5: order, difference, midpoint
    logic [TOTAL_W-1:0] zs4_reg, tot4_reg, tot4_next;
    logic               rev4_reg, rev4_next;
    logic [TOTAL_W:0]   diff;
    logic [TOTAL_W-1:0] z5_reg, z5_next;
    meta_t              meta5_reg, meta6_reg, meta7_reg, meta8_reg;
    meta_t              meta9_reg, meta10_reg, meta11_reg, meta12_reg, meta13_reg;
    meta_t              meta5_next;

    // Stage 6..8: era and day of era
    logic [TOTAL_W-1:0] z6_reg;
    logic [4:0]         q6_reg, q6_next, q7_reg;
    logic [20:0]        eprod;
    logic [22:0]        rfull;
    logic [18:0]        r7_reg, r7_next;
    logic [4:0]         era8_reg, era9_reg, era10_reg, era11_reg, era12_reg;
    logic [4:0]         era8_next;
    logic [17:0]        doe8_reg, doe9_reg, doe10_reg, doe8_next;

    // Stage 9..12: year of era, day of year, month
    logic [17:0]        n9_reg, n9_next;
    logic [9:0]         q1460;
    logic [2:0]         cent;
    logic [9:0]         yq;
    logic [8:0]         yoe10_reg, yoe11_reg, yoe12_reg, yoe10_next;
    logic [17:0]        ybase;
    logic [17:0]        dfull;
    logic [8:0]         doy11_reg, doy12_reg, doy11_next;
    logic [3:0]         mp12_reg, mp12_next;

    // Stage 13: output word
    logic [DAY_W-1:0]   day13_reg, day13_next;
    logic [MON_W-1:0]   mon13_reg, mon13_next;
    logic [YEAR_W-1:0]  year13_reg, year13_next;
    logic [8:0]         dom;

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        adv[STAGES-1] = !v_reg[STAGES-1] || rsp.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign req.ready = adv[0];

    // Move valid bits along with their words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= req.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Stage 1: clamp, March-based year, centuries
    always_comb
    begin
        sa_next = date_pass_a(req.start_day, req.start_month, req.start_year);
        ea_next = date_pass_a(req.end_day, req.end_month, req.end_year);
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            sa_reg <= sa_next;
            ea_reg <= ea_next;
        end
    end

    // Stage 2: leap year, day clamp, day of year, linear year term
    always_comb
    begin
        sb_next = date_pass_b(sa_reg);
        eb_next = date_pass_b(ea_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            sb_reg <= sb_next;
            eb_reg <= eb_next;
        end
    end

    // Stage 3: day numbers
    always_comb
    begin
        zs3_next = date_pass_c(sb_reg);
        ze3_next = date_pass_c(eb_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            zs3_reg <= zs3_next;
            ze3_reg <= ze3_next;
        end
    end

    // Stage 4: difference; a borrow marks reversed dates
    always_comb
    begin
        diff      = {1'b0, ze3_reg} - {1'b0, zs3_reg};
        rev4_next = diff[TOTAL_W];
        tot4_next = rev4_next ? '0 : diff[TOTAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            zs4_reg  <= zs3_reg;
            tot4_reg <= tot4_next;
            rev4_reg <= rev4_next;
        end
    end

    // Stage 5: midpoint day number, rounded down
    always_comb
    begin
        z5_next         = zs4_reg + (tot4_reg >> 1);
        meta5_next.total = tot4_reg;
        meta5_next.noon  = tot4_reg[0];
        meta5_next.rev   = rev4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            z5_reg    <= z5_next;
            meta5_reg <= meta5_next;
        end
    end

    // Stage 6: era estimate, never above the true era
    always_comb
    begin
        eprod   = 21'(z5_reg[TOTAL_W-1:ERA_PRE]) * 21'(ERA_K);
        q6_next = eprod[20:ERA_SH-ERA_PRE];
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            z6_reg    <= z5_reg;
            q6_reg    <= q6_next;
            meta6_reg <= meta5_reg;
        end
    end

    // Stage 7: remainder against the estimate
    always_comb
    begin
        rfull   = 23'(z6_reg) - 23'(q6_reg) * 23'(DAYS_PER_ERA);
        r7_next = rfull[18:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            r7_reg    <= r7_next;
            q7_reg    <= q6_reg;
            meta7_reg <= meta6_reg;
        end
    end

    // Stage 8: correct the era by one where the remainder overflows
    always_comb
    begin
        if (r7_reg >= 19'(DAYS_PER_ERA))
        begin
            era8_next = q7_reg + 5'd1;
            doe8_next = 18'(r7_reg - 19'(DAYS_PER_ERA));
        end
        else
        begin
            era8_next = q7_reg;
            doe8_next = r7_reg[17:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            era8_reg  <= era8_next;
            doe8_reg  <= doe8_next;
            meta8_reg <= meta7_reg;
        end
    end

    // Stage 9: drop leap days from the day of era
    always_comb
    begin
        q1460 = div365(18'(doe8_reg >> 2));
        cent  = 3'(doe8_reg >= 18'(DAYS_PER_CENTURY))
              + 3'(doe8_reg >= 18'(2 * DAYS_PER_CENTURY))
              + 3'(doe8_reg >= 18'(3 * DAYS_PER_CENTURY))
              + 3'(doe8_reg >= 18'(4 * DAYS_PER_CENTURY));
        n9_next = doe8_reg - 18'(q1460) + 18'(cent)
                - 18'(doe8_reg == 18'(DAYS_PER_ERA - 1));
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            n9_reg    <= n9_next;
            doe9_reg  <= doe8_reg;
            era9_reg  <= era8_reg;
            meta9_reg <= meta8_reg;
        end
    end

    // Stage 10: year of era
    always_comb
    begin
        yq         = div365(n9_reg);
        yoe10_next = yq[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            yoe10_reg  <= yoe10_next;
            doe10_reg  <= doe9_reg;
            era10_reg  <= era9_reg;
            meta10_reg <= meta9_reg;
        end
    end

    // Stage 11: day of the March-based year
    always_comb
    begin
        ybase      = 18'(yoe10_reg) * 18'd365 + 18'(yoe10_reg >> 2)
                   - 18'(div25(12'(yoe10_reg >> 2)));
        dfull      = doe10_reg - ybase;
        doy11_next = dfull[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            doy11_reg  <= doy11_next;
            yoe11_reg  <= yoe10_reg;
            era11_reg  <= era10_reg;
            meta11_reg <= meta10_reg;
        end
    end

    // Stage 12: March-based month
    always_comb
    begin
        mp12_next = div153(11'(doy11_reg) * 11'd5 + 11'd2);
    end

    always_ff @(posedge clk)
    begin
        if (adv[11])
        begin
            mp12_reg   <= mp12_next;
            doy12_reg  <= doy11_reg;
            yoe12_reg  <= yoe11_reg;
            era12_reg  <= era11_reg;
            meta12_reg <= meta11_reg;
        end
    end

    // Stage 13: day, calendar month and year of the midpoint
    always_comb
    begin
        dom         = doy12_reg - month_start(mp12_reg) + 9'd1;
        day13_next  = dom[DAY_W-1:0];
        mon13_next  = (mp12_reg < 4'd10) ? mp12_reg + 4'd3 : mp12_reg - 4'd9;
        year13_next = YEAR_W'(yoe12_reg) + YEAR_W'(14'(era12_reg) * 14'd400)
                    + YEAR_W'(mon13_next <= MON_W'(2));
    end

    always_ff @(posedge clk)
    begin
        if (adv[12])
        begin
            day13_reg  <= day13_next;
            mon13_reg  <= mon13_next;
            year13_reg <= year13_next;
            meta13_reg <= meta12_reg;
        end
    end

    // Drive the response word
    assign rsp.valid      = v_reg[STAGES-1];
    assign rsp.total_days = meta13_reg.total;
    assign rsp.mid_day    = day13_reg;
    assign rsp.mid_month  = mon13_reg;
    assign rsp.mid_year   = year13_reg;
    assign rsp.noon_flag  = meta13_reg.noon;
    assign rsp.reversed   = meta13_reg.rev;

endmodule

// File: hw/rtl/gdm_checker.sv
// ----------------------------------------------------------------------------
// gdm_checker
// Port-level checks on the response channel of the date midpoint block.
// ----------------------------------------------------------------------------
`include "gregorian_date_midpoint_top_assert.svh"

module gdm_checker
    import gdm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [TOTAL_W-1:0] total_days,
    input logic [DAY_W-1:0]   mid_day,
    input logic [MON_W-1:0]   mid_month,
    input logic [YEAR_W-1:0]  mid_year,
    input logic               noon_flag,
    input logic               reversed
);

    // Hold a stalled word
    `GDM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(total_days) && $stable(mid_year), "stalled response word changed")

    // Reversed dates give a zero count and no noon midpoint
    `GDM_ASSERT_IMP(a_rev_zero, rsp_valid && reversed, total_days == '0 && !noon_flag, "reversed word has nonzero count or noon flag")

    // Noon flag follows the parity of the count
    `GDM_ASSERT_IMP(a_noon_parity, rsp_valid, noon_flag == total_days[0], "noon flag disagrees with day count parity")

    // Midpoint fields are in range: nonzero day and year, month 1 to 12
    `GDM_ASSERT_IMP(a_mid_range, rsp_valid, mid_day != '0 && mid_month != '0 && mid_month <= MON_W'(12) && mid_year != '0, "midpoint date out of range")

endmodule

bind gregorian_date_midpoint_top gdm_checker u_gdm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .total_days (rsp.total_days),
    .mid_day    (rsp.mid_day),
    .mid_month  (rsp.mid_month),
    .mid_year   (rsp.mid_year),
    .noon_flag  (rsp.noon_flag),
    .reversed   (rsp.reversed)
);

// File: test/gregorian_date_midpoint_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date midpoint testbench
// Sends date pairs into gregorian_date_midpoint_top. The pairs come first
// from a fixed table, then from a random mix: ordered spans, reversed pairs
// and raw out-of-range fields. Both sides idle at random. Every response
// word is checked field by field against typed table values or a day-number calendar predictor.
// ----------------------------------------------------------------------------
module gregorian_date_midpoint_top_test;
    import gdm_pkg::*;

    localparam int unsigned N_PLAN    = 22;
    localparam int unsigned N_RANDOM  = 650;
    localparam int unsigned CALM_TAIL = 100;
    localparam int unsigned ERA_DAYS  = 146097;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } date_t;

    typedef struct packed {
        date_t first;
        date_t second;
    } date_pair_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [DAY_W-1:0]   day;
        logic [MON_W-1:0]   month;
        logic [YEAR_W-1:0]  year;
        logic               noon;
        logic               rev;
    } midpoint_t;

    logic        clk = 1'b0;
    logic        rst_n;
    int          errors = 0;
    bit          idling_on;
    int unsigned stall_left = 0;
    midpoint_t   midpoint_q [$];

    // Directed pairs. Columns: start day, month, year, end day, month, year,
    // then a typed flag and, where set, total, mid day, month, year, noon, rev.
    int unsigned plan [N_PLAN][13] = '{
        // equal dates
        '{1, 1, 2000, 1, 1, 2000,         1, 0, 1, 1, 2000, 0, 0},
        // one day apart: noon on the start date
        '{1, 1, 2000, 2, 1, 2000,         1, 1, 1, 1, 2000, 1, 0},
        '{1, 1, 2000, 3, 1, 2000,         1, 2, 2, 1, 2000, 0, 0},
        // across a year boundary
        '{31, 12, 2019, 1, 1, 2020,       1, 1, 31, 12, 2019, 1, 0},
        // leap day in the middle
        '{28, 2, 2000, 1, 3, 2000,        1, 2, 29, 2, 2000, 0, 0},
        // century year without a leap day
        '{28, 2, 1900, 1, 3, 1900,        1, 1, 28, 2, 1900, 1, 0},
        // reversed pair
        '{10, 5, 2020, 1, 1, 2019,        1, 0, 10, 5, 2020, 0, 1},
        // all-zero fields clamp to the first day of year one
        '{0, 0, 0, 0, 0, 0,               1, 0, 1, 1, 1, 0, 0},
        // all-ones fields clamp to the last day of the last year
        '{31, 15, 16383, 31, 15, 16383,   1, 0, 31, 12, 9999, 0, 0},
        // day beyond the month end clamps to the month end
        '{31, 2, 2001, 31, 2, 2001,       1, 0, 28, 2, 2001, 0, 0},
        '{31, 2, 2000, 0, 3, 2000,        1, 1, 29, 2, 2000, 1, 0},
        '{31, 4, 2021, 1, 1, 2021,        1, 0, 30, 4, 2021, 0, 1},
        '{29, 2, 2100, 1, 3, 2100,        1, 1, 28, 2, 2100, 1, 0},
        // clamped reversed extremes
        '{0, 0, 16383, 31, 15, 0,         1, 0, 1, 1, 9999, 0, 1},
        '{31, 12, 9999, 1, 1, 1,          1, 0, 31, 12, 9999, 0, 1},
        // full range and era boundaries, left to the predictor
        '{1, 1, 1, 31, 12, 9999,          0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, 1, 1, 9999,            0, 0, 0, 0, 0, 0, 0},
        '{1, 3, 2000, 1, 3, 2400,         0, 0, 0, 0, 0, 0, 0},
        '{15, 6, 1600, 15, 6, 2000,       0, 0, 0, 0, 0, 0, 0},
        '{1, 1, 1, 1, 1, 2,               0, 0, 0, 0, 0, 0, 0},
        '{31, 1, 2023, 31, 12, 2023,      0, 0, 0, 0, 0, 0, 0},
        '{17, 8, 10, 30, 9, 5000,         0, 0, 0, 0, 0, 0, 0}
    };

    gdm_req_if req_ch ();
    gdm_rsp_if rsp_ch ();

    gregorian_date_midpoint_top i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #6 clk = ~clk;

    // --------------------------------------------------------------------
    // Calendar predictor
    // --------------------------------------------------------------------
    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            2:             n = is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Clamp raw fields to a real date
    function automatic date_t fix_date(input date_t raw);
        date_t r;
        int unsigned y, m, d;
        y = (raw.year == 0) ? 1 : (raw.year > YEAR_LIMIT) ? YEAR_LIMIT : raw.year;
        m = (raw.month == 0) ? 1 : (raw.month > 12) ? 12 : raw.month;
        d = (raw.day == 0) ? 1 : raw.day;
        if (d > month_days(m, y))
            d = month_days(m, y);
        r.day   = DAY_W'(d);
        r.month = MON_W'(m);
        r.year  = YEAR_W'(y);
        return r;
    endfunction

    // Days since March 1 of year zero
    function automatic int unsigned day_index(input date_t dt);
        int unsigned yy, mp;
        yy = (dt.month <= 2) ? dt.year - 1 : dt.year;
        mp = (dt.month > 2) ? dt.month - 3 : dt.month + 9;
        return yy * 365 + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + dt.day - 1;
    endfunction

    function automatic date_t index_to_date(input int unsigned z);
        date_t       r;
        int unsigned era, doe, yoe, doy, mp, m;
        era = z / ERA_DAYS;
        doe = z - era * ERA_DAYS;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        r.day   = DAY_W'(doy - (153 * mp + 2) / 5 + 1);
        r.month = MON_W'(m);
        r.year  = YEAR_W'(yoe + era * 400 + ((m <= 2) ? 1 : 0));
        return r;
    endfunction

    function automatic midpoint_t predict_midpoint(input date_pair_t p);
        midpoint_t   r;
        date_t       a, b, mid;
        int unsigned za, zb, span;
        a  = fix_date(p.first);
        b  = fix_date(p.second);
        za = day_index(a);
        zb = day_index(b);
        if (zb < za)
        begin
            r = '{total: '0, day: a.day, month: a.month, year: a.year, noon: 1'b0, rev: 1'b1};
        end
        else
        begin
            span = zb - za;
            mid  = index_to_date(za + span / 2);
            r = '{total: TOTAL_W'(span), day: mid.day, month: mid.month, year: mid.year,
                  noon: span[0], rev: 1'b0};
        end
        return r;
    endfunction

    // --------------------------------------------------------------------
    // Stimulus generation
    // --------------------------------------------------------------------
    function automatic date_t random_date(input int unsigned y);
        date_t       r;
        int unsigned m;
        m = $urandom_range(1, 12);
        r.year  = YEAR_W'(y);
        r.month = MON_W'(m);
        r.day   = DAY_W'($urandom_range(1, month_days(m, y)));
        return r;
    endfunction

    // Mostly ordered real dates; some reversed, some raw field noise
    function automatic date_pair_t random_pair();
        date_pair_t  p;
        date_t       t;
        int unsigned pick, y0, y1;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            p.first  = '{day: DAY_W'($urandom_range(0, 31)),
                         month: MON_W'($urandom_range(0, 15)),
                         year: YEAR_W'($urandom_range(0, 16383))};
            p.second = '{day: DAY_W'($urandom_range(0, 31)),
                         month: MON_W'($urandom_range(0, 15)),
                         year: YEAR_W'($urandom_range(0, 16383))};
        end
        else
        begin
            y0 = $urandom_range(1, YEAR_LIMIT);
            if (pick < 15)
            begin
                y0 = 1;
                y1 = YEAR_LIMIT;
            end
            else if (pick < 40)
                y1 = y0;
            else if (pick < 70)
                y1 = (y0 + 3 > YEAR_LIMIT) ? YEAR_LIMIT : y0 + $urandom_range(0, 3);
            else if (pick < 85)
                y1 = $urandom_range(y0, YEAR_LIMIT);
            else
                y1 = $urandom_range(1, YEAR_LIMIT);
            p.first  = random_date(y0);
            p.second = random_date(y1);
            // keep order except in the free-order slice
            if (pick < 85 && day_index(p.second) < day_index(p.first))
            begin
                t        = p.first;
                p.first  = p.second;
                p.second = t;
            end
        end
        return p;
    endfunction

    // --------------------------------------------------------------------
    // Request side
    // --------------------------------------------------------------------
    task automatic idle_sender();
        if (idling_on && $urandom_range(0, 4) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        req_ch.valid <= 1'b0;
        while (midpoint_q.size() != 0)
            @(posedge clk);
    endtask

    // Present one word, wait for the handshake, record the expectation
    task automatic send_pair(input date_pair_t p, input midpoint_t want);
        req_ch.valid       <= 1'b1;
        req_ch.start_day   <= p.first.day;
        req_ch.start_month <= p.first.month;
        req_ch.start_year  <= p.first.year;
        req_ch.end_day     <= p.second.day;
        req_ch.end_month   <= p.second.month;
        req_ch.end_year    <= p.second.year;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        midpoint_q.push_back(want);
    endtask

    initial
    begin
        date_pair_t pair;
        midpoint_t  want;
        rst_n              <= 1'b0;
        idling_on          <= 1'b1;
        req_ch.valid       <= 1'b0;
        req_ch.start_day   <= '0;
        req_ch.start_month <= '0;
        req_ch.start_year  <= '0;
        req_ch.end_day     <= '0;
        req_ch.end_month   <= '0;
        req_ch.end_year    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < N_PLAN; i++)
        begin
            pair.first  = '{day: DAY_W'(plan[i][0]), month: MON_W'(plan[i][1]),
                            year: YEAR_W'(plan[i][2])};
            pair.second = '{day: DAY_W'(plan[i][3]), month: MON_W'(plan[i][4]),
                            year: YEAR_W'(plan[i][5])};
            if (plan[i][6] != 0)
                want = '{total: TOTAL_W'(plan[i][7]), day: DAY_W'(plan[i][8]),
                         month: MON_W'(plan[i][9]), year: YEAR_W'(plan[i][10]),
                         noon: plan[i][11][0], rev: plan[i][12][0]};
            else
                want = predict_midpoint(pair);
            idle_sender();
            send_pair(pair, want);
        end
        hold_until_drained();

        // Random mix; drop idling on both sides for the tail
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
                hold_until_drained();
            if (n == N_RANDOM - CALM_TAIL)
                idling_on <= 1'b0;
            pair = random_pair();
            idle_sender();
            send_pair(pair, predict_midpoint(pair));
        end
        req_ch.valid <= 1'b0;

        while (midpoint_q.size() != 0)
            @(posedge clk);
        repeat (2 * STAGES) @(posedge clk);
        if (errors == 0)
            $display("gregorian_date_midpoint_top_test: done, clean");
        else
            $display("gregorian_date_midpoint_top_test: done, errors");
        $finish;
    end

    // --------------------------------------------------------------------
    // Response side
    // --------------------------------------------------------------------
    // Stall at random while idling is on
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left != 0)
            stall_left--;
        else if (idling_on && $urandom_range(0, 7) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Match each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        midpoint_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (midpoint_q.size() == 0)
            begin
                $display("%0t: word expected none, got total_days %0d mid %0d-%0d-%0d",
                         $time, rsp_ch.total_days, rsp_ch.mid_year, rsp_ch.mid_month,
                         rsp_ch.mid_day);
                errors++;
            end
            else
            begin
                want = midpoint_q.pop_front();
                check_field("total_days", want.total, rsp_ch.total_days);
                check_field("mid_day", want.day, rsp_ch.mid_day);
                check_field("mid_month", want.month, rsp_ch.mid_month);
                check_field("mid_year", want.year, rsp_ch.mid_year);
                check_field("noon_flag", want.noon, rsp_ch.noon_flag);
                check_field("reversed", want.rev, rsp_ch.reversed);
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("gregorian_date_midpoint_top_test: done, errors");
        $finish;
    end

endmodule
